[hw/rtl/wpnm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpnm_pkg
// shared constants, configuration codes and interface types of the
// window percentile near-miss core
// ----------------------------------------------------------------------------
package wpnm_pkg;

    localparam int HISTORY_DEPTH = 64;
    localparam int ADDR_W        = $clog2(HISTORY_DEPTH);
    localparam int FILL_W        = $clog2(HISTORY_DEPTH + 1);
    localparam int LEVEL_W       = 9;
    localparam int WARM_W        = 6;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 9;
    localparam int CMP_W         = (FILL_W > WARM_W) ? FILL_W : WARM_W;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 9'd256;

    // rank = floor(9n/10) is tracked incrementally as n grows
    localparam int RANK_NUM = 9;
    localparam int RANK_DEN = 10;
    localparam int REM_W    = 5;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WARMUP   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FALLBACK = 2'd2;

    localparam logic [WARM_W-1:0]  RST_WARMUP   = 6'd10;
    localparam logic [LEVEL_W-1:0] RST_MIN      = 9'd18;
    localparam logic [LEVEL_W-1:0] RST_FALLBACK = 9'd20;

    typedef struct packed {
        logic [WARM_W-1:0]  warmup_count;
        logic [LEVEL_W-1:0] min_level;
        logic [LEVEL_W-1:0] fallback_level;
    } t_cfg;

    typedef struct packed {
        logic valid;
        logic flag;
    } t_result;

endpackage

[hw/rtl/wpnm_hist_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpnm_hist_ram
// single write port, single registered read port history memory
// ----------------------------------------------------------------------------
module wpnm_hist_ram #(
    parameter int DEPTH  = 64,
    parameter int WIDTH  = 9,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[hw/rtl/wpnm_seq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpnm_seq
// item sequencer: in percentile mode scans the stored history and counts entries
// not above the level; decides the flag and pushes the level into the ring
// ----------------------------------------------------------------------------
module wpnm_seq import wpnm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic [LEVEL_W-1:0] i_level,
    output logic               o_in_ready,
    input  t_cfg               i_cfg,
    input  logic               i_out_free,
    output t_result            o_result,
    output logic               o_rd_en,
    output logic [ADDR_W-1:0]  o_rd_addr,
    input  logic [LEVEL_W-1:0] i_rd_data,
    output logic               o_wr_en,
    output logic [ADDR_W-1:0]  o_wr_addr,
    output logic [LEVEL_W-1:0] o_wr_data
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_PUSH  = 4'b1000
    } t_state;

    t_state             r_state, n_state;
    logic [LEVEL_W-1:0] r_lvl, n_lvl;
    logic               r_pct, n_pct;
    logic [ADDR_W-1:0]  r_idx, n_idx;
    logic               r_rd_vld, n_rd_vld;
    logic [FILL_W-1:0]  r_cnt, n_cnt;
    logic [ADDR_W-1:0]  r_wp, n_wp;
    logic [FILL_W-1:0]  r_fill, n_fill;
    logic [FILL_W-1:0]  r_rank, n_rank;
    logic [REM_W-1:0]   r_rem, n_rem;

    logic [LEVEL_W-1:0] w_lvl_sat;
    logic [FILL_W-1:0]  w_fill_m1;
    logic [REM_W-1:0]   w_rem_sum;
    logic               w_pct;
    logic               w_flag;
    logic               w_push;

    always_comb begin
        w_lvl_sat = (i_level > LEVEL_MAX) ? LEVEL_MAX : i_level;
        w_fill_m1 = r_fill - FILL_W'(1);
        w_rem_sum = r_rem + REM_W'(RANK_NUM);
        w_pct     = CMP_W'(r_fill) > CMP_W'(i_cfg.warmup_count);
        w_flag    = r_pct ? ((r_cnt > r_rank) && (r_lvl >= i_cfg.min_level))
                          : (r_lvl >= i_cfg.fallback_level);
        w_push    = (r_state == ST_PUSH) && i_out_free;

        n_state  = r_state;
        n_lvl    = r_lvl;
        n_pct    = r_pct;
        n_idx    = r_idx;
        n_rd_vld = (r_state == ST_SCAN);
        n_cnt    = r_cnt;
        n_wp     = r_wp;
        n_fill   = r_fill;
        n_rank   = r_rank;
        n_rem    = r_rem;

        // read data is registered and arrives in the cycle after its address
        if (r_rd_vld && (i_rd_data <= r_lvl)) begin
            n_cnt = r_cnt + FILL_W'(1);
        end

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_lvl   = w_lvl_sat;
                    n_pct   = w_pct;
                    n_cnt   = '0;
                    n_idx   = '0;
                    n_state = w_pct ? ST_SCAN : ST_PUSH;
                end
            end
            ST_SCAN: begin
                if (r_idx == w_fill_m1[ADDR_W-1:0]) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_idx = r_idx + ADDR_W'(1);
                end
            end
            ST_DRAIN: begin
                n_state = ST_PUSH;
            end
            ST_PUSH: begin
                if (i_out_free) begin
                    n_wp = (r_wp == ADDR_W'(HISTORY_DEPTH - 1)) ? '0 : r_wp + ADDR_W'(1);
                    if (r_fill != FILL_W'(HISTORY_DEPTH)) begin
                        n_fill = r_fill + FILL_W'(1);
                        if (w_rem_sum >= REM_W'(RANK_DEN)) begin
                            n_rank = r_rank + FILL_W'(1);
                            n_rem  = w_rem_sum - REM_W'(RANK_DEN);
                        end else begin
                            n_rem  = w_rem_sum;
                        end
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_rd_vld <= 1'b0;
            r_wp     <= '0;
            r_fill   <= '0;
            r_rank   <= '0;
            r_rem    <= '0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= n_rd_vld;
            r_wp     <= n_wp;
            r_fill   <= n_fill;
            r_rank   <= n_rank;
            r_rem    <= n_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lvl <= n_lvl;
        r_pct <= n_pct;
        r_idx <= n_idx;
        r_cnt <= n_cnt;
    end

    assign o_in_ready     = (r_state == ST_IDLE);
    assign o_rd_en        = (r_state == ST_SCAN);
    assign o_rd_addr      = r_idx;
    assign o_wr_en        = w_push;
    assign o_wr_addr      = r_wp;
    assign o_wr_data      = r_lvl;
    assign o_result.valid = w_push;
    assign o_result.flag  = w_flag;

endmodule

[hw/rtl/window_percentile_near_miss_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// window_percentile_near_miss_core
// flags a level that reaches both the 90th percentile of the recent history and
// the minimum level, or a static threshold while the history is warming up
// sequence: in percentile mode an accepted level passes SCAN (one history read
//   per cycle), DRAIN and PUSH; in fallback mode it goes straight to PUSH
// input: ready only in IDLE; a new word waits until the previous one is pushed
// reset: synchronous active low; clears pointer, fill count and output valid,
//   loads register defaults; history memory is not cleared
// ----------------------------------------------------------------------------
module window_percentile_near_miss_core import wpnm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [LEVEL_W-1:0]    i_level,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_near_miss,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_cfg               r_cfg;
    logic               r_out_vld;
    logic               r_out_nm;
    logic               w_out_free;
    t_result            w_result;
    logic               w_rd_en;
    logic [ADDR_W-1:0]  w_rd_addr;
    logic [LEVEL_W-1:0] w_rd_data;
    logic               w_wr_en;
    logic [ADDR_W-1:0]  w_wr_addr;
    logic [LEVEL_W-1:0] w_wr_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.warmup_count   <= RST_WARMUP;
            r_cfg.min_level      <= RST_MIN;
            r_cfg.fallback_level <= RST_FALLBACK;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_WARMUP:   r_cfg.warmup_count   <= i_cfg_wdata[WARM_W-1:0];
                CFG_MIN:      r_cfg.min_level      <= i_cfg_wdata[LEVEL_W-1:0];
                CFG_FALLBACK: r_cfg.fallback_level <= i_cfg_wdata[LEVEL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // output word register
    assign w_out_free = !r_out_vld || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_result.valid) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_result.valid) begin
            r_out_nm <= w_result.flag;
        end
    end

    wpnm_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_level    (i_level),
        .o_in_ready (o_in_ready),
        .i_cfg      (r_cfg),
        .i_out_free (w_out_free),
        .o_result   (w_result),
        .o_rd_en    (w_rd_en),
        .o_rd_addr  (w_rd_addr),
        .i_rd_data  (w_rd_data),
        .o_wr_en    (w_wr_en),
        .o_wr_addr  (w_wr_addr),
        .o_wr_data  (w_wr_data)
    );

    wpnm_hist_ram #(
        .DEPTH  (HISTORY_DEPTH),
        .WIDTH  (LEVEL_W),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    assign o_out_valid = r_out_vld;
    assign o_near_miss = r_out_nm;

endmodule

[hw/rtl/wpnm_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpnm_checker
// port level checks of the near-miss core, bound to the top level
// ----------------------------------------------------------------------------
module wpnm_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input logic o_out_valid,
    input logic i_out_ready,
    input logic o_near_miss
);

    // one word at a time: ready drops right after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input ready still high after accept");

    // a result never shows up the cycle after its accept
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !$rose(o_out_valid))
        else $error("result appeared too early");

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid not cleared by reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_near_miss)))
        else $error("stalled output word changed");

endmodule

bind window_percentile_near_miss_core wpnm_checker u_wpnm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_near_miss (o_near_miss)
);

[tb/sv/near_miss_watch.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// near_miss_watch
// follows both channels and the register port of the near-miss core, keeps
// its own window of recent levels and checks every output flag in order
// ----------------------------------------------------------------------------
module near_miss_watch import wpnm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic [LEVEL_W-1:0]    i_level,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic                  i_near_miss,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output int                    o_mismatches,
    output int                    o_flags_due,
    output int                    o_results_seen,
    output int                    o_flags_raised
);

    t_cfg               cfg;
    logic [LEVEL_W-1:0] window [HISTORY_DEPTH];
    logic [ADDR_W-1:0]  wr_ptr;
    int                 fill;
    logic               pending_flags [$];

    // flag for a saturated level against the window as it stands now
    function automatic logic level_flags(input logic [LEVEL_W-1:0] lvl);
        int rank;
        int not_above;
        if (fill > int'(cfg.warmup_count)) begin
            rank = (RANK_NUM * fill) / RANK_DEN;
            if (rank >= fill)
                rank = fill - 1;
            not_above = 0;
            for (int k = 0; k < fill; k++)
                if (window[k] <= lvl)
                    not_above++;
            return (not_above >= rank + 1) && (lvl >= cfg.min_level);
        end
        return lvl >= cfg.fallback_level;
    endfunction

    always @(posedge i_clk) begin
        logic [LEVEL_W-1:0] lvl;
        logic               want;
        if (!i_rst_n) begin
            cfg.warmup_count   = RST_WARMUP;
            cfg.min_level      = RST_MIN;
            cfg.fallback_level = RST_FALLBACK;
            wr_ptr             = '0;
            fill               = 0;
            pending_flags.delete();
            o_mismatches       = 0;
            o_results_seen     = 0;
            o_flags_raised     = 0;
        end else begin
            // results first: a word may leave on the edge a new one arrives
            if (i_out_valid && i_out_ready) begin
                o_results_seen++;
                if (i_near_miss === 1'b1)
                    o_flags_raised++;
                if (pending_flags.size() == 0) begin
                    $error("o_near_miss unexpected: expected none actual %0b", i_near_miss);
                    o_mismatches++;
                end else begin
                    want = pending_flags.pop_front();
                    if (i_near_miss !== want) begin
                        $error("o_near_miss mismatch: expected %0b actual %0b",
                               want, i_near_miss);
                        o_mismatches++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                lvl = (i_level > LEVEL_MAX) ? LEVEL_MAX : i_level;
                pending_flags.push_back(level_flags(lvl));
                window[wr_ptr] = lvl;
                wr_ptr = (int'(wr_ptr) == HISTORY_DEPTH - 1) ? '0 : wr_ptr + ADDR_W'(1);
                if (fill < HISTORY_DEPTH)
                    fill++;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_WARMUP:   cfg.warmup_count   = i_cfg_wdata[WARM_W-1:0];
                    CFG_MIN:      cfg.min_level      = i_cfg_wdata[LEVEL_W-1:0];
                    CFG_FALLBACK: cfg.fallback_level = i_cfg_wdata[LEVEL_W-1:0];
                    default: ;
                endcase
            end
        end
        o_flags_due = pending_flags.size();
    end

endmodule

[tb/sv/window_percentile_near_miss_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// window_percentile_near_miss_core_tb
// drives level words and register settings into the near-miss core with
// random gaps and back-pressure; the watch module checks every flag
// ----------------------------------------------------------------------------
module window_percentile_near_miss_core_tb;
    import wpnm_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int RANDOM_WORDS = 800;
    localparam int DRAIN_CYCLES = HISTORY_DEPTH + 8;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic [LEVEL_W-1:0]    i_level     = '0;
    logic                  i_out_ready = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  o_in_ready;
    logic                  o_out_valid;
    logic                  o_near_miss;

    int mismatches;
    int flags_due;
    int results_seen;
    int flags_raised;

    int                 words_sent = 0;
    int                 settings   = 0;
    bit                 quiet      = 1'b0;
    logic [LEVEL_W-1:0] recent     = '0;

    window_percentile_near_miss_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_level     (i_level),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_near_miss (o_near_miss),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    near_miss_watch u_watch (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_level        (i_level),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_near_miss    (o_near_miss),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_mismatches   (mismatches),
        .o_flags_due    (flags_due),
        .o_results_seen (results_seen),
        .o_flags_raised (flags_raised)
    );

    always #6 i_clk = ~i_clk;

    // mostly short gaps, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(99);
        if (quiet)
            return 0;
        if (r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 16);
        return $urandom_range(20, 120);
    endfunction

    function automatic logic [LEVEL_W-1:0] pick_level(input int style,
                                                      input logic [LEVEL_W-1:0] lo);
        int r;
        r = $urandom_range(99);
        // narrow band: dense ties around the percentile
        if (style == 1 && r < 80)
            return lo + LEVEL_W'($urandom_range(0, 6));
        if (r < 35)
            return LEVEL_W'($urandom_range(0, 40));
        if (r < 60)
            return LEVEL_W'($urandom_range(0, 256));
        if (r < 70)
            return LEVEL_W'($urandom_range(257, 511));
        if (r < 78)
            return LEVEL_MAX;
        if (r < 85)
            return '0;
        return recent;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_threshold();
        int r;
        r = $urandom_range(99);
        if (r < 15)
            return '0;
        if (r < 30)
            return LEVEL_MAX;
        if (r < 40)
            return CFG_DATA_W'($urandom_range(257, 511));
        if (r < 70)
            return CFG_DATA_W'($urandom_range(0, 60));
        return CFG_DATA_W'($urandom_range(0, 256));
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_warmup();
        int r;
        r = $urandom_range(99);
        // upper data bits are random, only the low six count
        if (r < 25)
            return {3'($urandom_range(0, 7)), 6'd0};
        if (r < 50)
            return {3'($urandom_range(0, 7)), 6'd63};
        return CFG_DATA_W'($urandom_range(0, 511));
    endfunction

    task automatic send_level(input logic [LEVEL_W-1:0] lvl);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_level    <= lvl;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
        recent = (lvl > LEVEL_MAX) ? LEVEL_MAX : lvl;
        words_sent++;
    endtask

    // hold the sender until every flag is back
    task automatic let_drain();
        i_in_valid <= 1'b0;
        while (flags_due != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] warm,
                             input logic [CFG_DATA_W-1:0] minl,
                             input logic [CFG_DATA_W-1:0] fb,
                             input logic [3:0]            mask);
        logic [CFG_DATA_W-1:0] data [4];
        logic [CFG_IDX_W-1:0]  regs [4];
        data[0] = warm;
        data[1] = minl;
        data[2] = fb;
        data[3] = CFG_DATA_W'($urandom_range(0, 511));
        regs[0] = CFG_WARMUP;
        regs[1] = CFG_MIN;
        regs[2] = CFG_FALLBACK;
        regs[3] = CFG_SPARE;
        for (int k = 0; k < 4; k++) begin
            if (mask[k]) begin
                i_cfg_we    <= 1'b1;
                i_cfg_idx   <= regs[k];
                i_cfg_wdata <= data[k];
                @(negedge i_clk);
            end
        end
        i_cfg_we <= 1'b0;
        settings++;
    endtask

    // receiver: runs of ready and stalls of random length
    initial begin
        int hold;
        int len;
        hold = 0;
        forever begin
            @(negedge i_clk);
            if (hold > 0) begin
                hold--;
            end else if (i_out_ready) begin
                len = idle_len();
                if (len == 0) begin
                    hold = $urandom_range(1, 20);
                end else begin
                    i_out_ready <= 1'b0;
                    hold = len - 1;
                end
            end else begin
                i_out_ready <= 1'b1;
                hold = $urandom_range(0, 20);
            end
        end
    end

    initial begin : stimulus
        int                 phase_len;
        int                 style;
        int                 random_sent;
        logic [LEVEL_W-1:0] lo;
        logic [3:0]         mask;

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // register defaults, fallback test, saturating levels
        send_level(9'd19);
        send_level(9'd20);
        send_level(9'd0);
        send_level(9'd511);
        send_level(9'd257);
        send_level(9'd256);

        // longest warmup, fallback out of reach
        let_drain();
        configure(9'h1FF, 9'd0, 9'd511, 4'b1111);
        send_level(9'd256);
        send_level(9'd0);
        send_level(9'd511);

        let_drain();
        configure('0, '0, 9'd0, 4'b0100);
        send_level(9'd0);
        send_level(9'd1);

        let_drain();
        configure('0, '0, LEVEL_MAX, 4'b0100);
        send_level(9'd255);
        send_level(9'd256);

        // percentile test from the first word on
        let_drain();
        configure(9'h0C0, 9'd0, '0, 4'b0011);
        send_level(9'd0);
        send_level(9'd511);
        send_level(9'd128);

        let_drain();
        configure('0, LEVEL_MAX, '0, 4'b0010);
        send_level(9'd256);
        send_level(9'd255);
        let_drain();
        configure('0, 9'h1FF, '0, 4'b0010);
        send_level(9'd256);

        // first random phase keeps the fallback test until the ring fills
        random_sent = 0;
        let_drain();
        configure(9'd63, pick_threshold(), pick_threshold(), 4'b0111);
        while (random_sent < RANDOM_WORDS) begin
            style = $urandom_range(0, 2) == 0 ? 1 : 0;
            lo    = LEVEL_W'($urandom_range(0, 250));
            quiet = ($urandom_range(0, 5) == 0);
            phase_len = $urandom_range(30, 90);
            for (int k = 0; k < phase_len; k++) begin
                if ($urandom_range(0, 59) == 0)
                    let_drain();
                send_level(pick_level(style, lo));
                random_sent++;
            end
            let_drain();
            mask = 4'($urandom_range(0, 15));
            if (mask[2:0] == 3'b000)
                mask[2'($urandom_range(0, 2))] = 1'b1;
            configure(pick_warmup(), pick_threshold(), pick_threshold(), mask);
        end

        i_in_valid <= 1'b0;
        while (flags_due != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("checked %0d flags (%0d raised) from %0d level words under %0d settings",
                 results_seen, flags_raised, words_sent, settings);
        $display("fallback and percentile tests, threshold extremes, saturation, ring wrap");
        if (mismatches == 0 && flags_due == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #12_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/wpnm_pkg.sv
hw/rtl/wpnm_hist_ram.sv
hw/rtl/wpnm_seq.sv
hw/rtl/window_percentile_near_miss_core.sv
hw/rtl/wpnm_checker.sv
tb/sv/near_miss_watch.sv
tb/sv/window_percentile_near_miss_core_tb.sv
